// ===== rtl/core/csbc_pkg.sv =====
// Shared types and constants for the canonical split bitset checker.
// No dependencies.
package csbc_pkg;

  localparam int BYTE_W     = 8;
  localparam int TAXON_W    = 13;
  localparam int STATUS_W   = 3;
  localparam int SEL_TAXA_W = 13;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;

  localparam logic [APB_ADDR_W-1:0] REG_NUM_TAXA = 2'd0;
  localparam logic [TAXON_W-1:0]    NUM_TAXA_RST = 13'd1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK            = 3'd0,
    STATUS_WIDTH         = 3'd1,
    STATUS_SEL_PADDING   = 3'd2,
    STATUS_RET_PADDING   = 3'd3,
    STATUS_NON_RETAINED  = 3'd4,
    STATUS_EMPTY_SIDE    = 3'd5,
    STATUS_NOT_CANONICAL = 3'd6
  } status_t;

endpackage

// ===== rtl/core/csbc_in_if.sv =====
// Input channel: one byte pair of the selected and retained bitsets.
// Depends on csbc_pkg.
interface csbc_in_if
  import csbc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  selected_byte;
  logic [BYTE_W-1:0]  retained_byte;
  logic               last_byte;

  modport source (output valid, selected_byte, retained_byte, last_byte, input ready);
  modport sink   (input valid, selected_byte, retained_byte, last_byte, output ready);
endinterface

// ===== rtl/core/csbc_out_if.sv =====
// Result channel: status and selected-side taxon count of one query.
// Depends on csbc_pkg.
interface csbc_out_if
  import csbc_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [SEL_TAXA_W-1:0]  selected_taxa;

  modport source (output valid, status, selected_taxa, input ready);
  modport sink   (input valid, status, selected_taxa, output ready);
endinterface

// ===== rtl/core/canonical_split_bitset_check_core.sv =====
// Canonical split bitset checker, top level.
// Depends on csbc_pkg, csbc_in_if and csbc_out_if.
//
// Takes one (selected, retained) byte pair per clock and, on the byte marked
// last, produces one status transaction with the selected-side popcount. An
// accepted byte is held in an input register, from which it updates the byte
// counter, popcount totals and order flags, and a last byte loads the
// result register once that register is free; the status is offered from
// there. The sustained rate is one byte pair per cycle; in_txn.ready drops
// only while a last byte waits in the input register for a full result
// register to be taken. The taxa count is written over APB at address 0 and
// is to be changed only while no query is in flight.
module canonical_split_bitset_check_core
  import csbc_pkg::*;
#(
  parameter int MAX_TAXA = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  csbc_in_if.sink                in_txn,
  csbc_out_if.source             out_txn,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int SEEN_CAP = (MAX_TAXA + 7) / 8 + 1;
  localparam int SEEN_W   = $clog2(SEEN_CAP + 1);
  localparam int TOT_W    = $clog2(SEEN_CAP * BYTE_W + 1);
  localparam logic [31:0] MAX_TAXA_U = 32'(MAX_TAXA);
  localparam int POP_W    = $clog2(BYTE_W + 1);

  function automatic logic [POP_W-1:0] ones8(input logic [BYTE_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

  // configuration
  logic [TAXON_W-1:0] num_taxa_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_NUM_TAXA);
  assign prdata = (paddr == REG_NUM_TAXA) ? APB_DATA_W'(num_taxa_r) : '0;

  logic [2:0]          rem;
  logic [BYTE_W-1:0]   pad_mask;
  logic [TAXON_W-1:0]  expected;
  logic                tc_bad;

  assign rem      = num_taxa_r[2:0];
  assign pad_mask = ~((8'd1 << rem) - 8'd1);
  assign expected = TAXON_W'(({1'b0, num_taxa_r} + 14'd7) >> 3);
  assign tc_bad   = (num_taxa_r == '0) || (32'(num_taxa_r) > MAX_TAXA_U);

  // input stage
  logic              s1_v_r, s1_v_nxt;
  logic              s1_last_r;
  logic [POP_W-1:0]  s1_pop_sel_r, s1_pop_comp_r;
  logic              s1_outside_r, s1_diff_r, s1_comp_lt_r;
  logic              s1_pad_sel_r, s1_pad_ret_r;
  logic [BYTE_W-1:0] comp;
  logic              in_acc, out_free, s1_go, s1_done;

  assign comp     = in_txn.retained_byte ^ in_txn.selected_byte;
  assign out_free = !out_txn.valid || out_txn.ready;
  assign s1_go    = s1_v_r && (!s1_last_r || out_free);
  assign s1_done  = s1_go && s1_last_r;
  assign in_txn.ready = !s1_v_r || s1_go;
  assign in_acc   = in_txn.valid && in_txn.ready;
  assign s1_v_nxt = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);

  // accumulation stage
  logic [SEEN_W-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [TOT_W-1:0]  sel_tot_r, sel_tot_nxt;
  logic [TOT_W-1:0]  comp_tot_r, comp_tot_nxt;
  logic              outside_r, outside_nxt;
  logic              decided_r, decided_nxt;
  logic              comp_first_r, comp_first_nxt;
  logic              below_cap;
  status_t           status;

  assign below_cap      = bytes_seen_r < SEEN_W'(SEEN_CAP);
  assign bytes_seen_nxt = bytes_seen_r + SEEN_W'(below_cap);
  assign sel_tot_nxt    = sel_tot_r + (below_cap ? TOT_W'(s1_pop_sel_r) : '0);
  assign comp_tot_nxt   = comp_tot_r + (below_cap ? TOT_W'(s1_pop_comp_r) : '0);
  assign outside_nxt    = outside_r || s1_outside_r;
  assign decided_nxt    = decided_r || s1_diff_r;
  assign comp_first_nxt = decided_r ? comp_first_r : (s1_diff_r && s1_comp_lt_r);

  always_comb begin
    if (tc_bad || (32'(bytes_seen_nxt) != 32'(expected))) begin
      status = STATUS_WIDTH;
    end else if ((rem != '0) && s1_pad_sel_r) begin
      status = STATUS_SEL_PADDING;
    end else if ((rem != '0) && s1_pad_ret_r) begin
      status = STATUS_RET_PADDING;
    end else if (outside_nxt) begin
      status = STATUS_NON_RETAINED;
    end else if ((sel_tot_nxt == '0) || (comp_tot_nxt == '0)) begin
      status = STATUS_EMPTY_SIDE;
    end else if ((sel_tot_nxt > comp_tot_nxt) ||
                 ((sel_tot_nxt == comp_tot_nxt) && decided_nxt && comp_first_nxt)) begin
      status = STATUS_NOT_CANONICAL;
    end else begin
      status = STATUS_OK;
    end
  end

  // result register
  logic                  out_v_r, out_v_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [SEL_TAXA_W-1:0] out_sel_r;

  assign out_v_nxt = s1_done ? 1'b1 : (out_txn.ready ? 1'b0 : out_v_r);
  assign out_txn.valid         = out_v_r;
  assign out_txn.status        = out_status_r;
  assign out_txn.selected_taxa = out_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_taxa_r    <= NUM_TAXA_RST;
      s1_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      bytes_seen_r  <= '0;
      sel_tot_r     <= '0;
      comp_tot_r    <= '0;
      outside_r     <= 1'b0;
      decided_r     <= 1'b0;
      comp_first_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        num_taxa_r <= pwdata[TAXON_W-1:0];
      end
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_go) begin
        if (s1_last_r) begin
          bytes_seen_r <= '0;
          sel_tot_r    <= '0;
          comp_tot_r   <= '0;
          outside_r    <= 1'b0;
          decided_r    <= 1'b0;
          comp_first_r <= 1'b0;
        end else begin
          bytes_seen_r <= bytes_seen_nxt;
          sel_tot_r    <= sel_tot_nxt;
          comp_tot_r   <= comp_tot_nxt;
          outside_r    <= outside_nxt;
          decided_r    <= decided_nxt;
          comp_first_r <= comp_first_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r     <= in_txn.last_byte;
      s1_pop_sel_r  <= ones8(in_txn.selected_byte);
      s1_pop_comp_r <= ones8(comp);
      s1_outside_r  <= (in_txn.selected_byte & ~in_txn.retained_byte) != '0;
      s1_diff_r     <= in_txn.selected_byte != comp;
      s1_comp_lt_r  <= comp < in_txn.selected_byte;
      s1_pad_sel_r  <= (in_txn.selected_byte & pad_mask) != '0;
      s1_pad_ret_r  <= (in_txn.retained_byte & pad_mask) != '0;
    end
    if (s1_done) begin
      out_status_r <= status;
      out_sel_r    <= SEL_TAXA_W'(sel_tot_nxt);
    end
  end

`ifndef SYNTH
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_done |=> out_v_r)
    else $error("last byte did not load a result");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_done |=> (bytes_seen_r == '0) && (sel_tot_r == '0) && (comp_tot_r == '0) && !decided_r)
    else $error("query state not cleared after last byte");

  a_seen_capped: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_seen_r <= SEEN_W'(SEEN_CAP))
    else $error("byte counter passed its cap");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_txn.ready |-> (s1_v_r && s1_last_r && out_v_r && !out_txn.ready))
    else $error("input stalled without a blocked result");
`endif

endmodule

// ===== tb/canonical_split_bitset_check_core_tb.sv =====
// Self-checking bench for canonical_split_bitset_check_core: directed and random
// bitset queries, APB setup of the taxa count, per-transaction status/popcount check.
// Depends on csbc_pkg, csbc_in_if, csbc_out_if and the core.
module canonical_split_bitset_check_core_tb;
  import csbc_pkg::*;

  localparam int MAX_TAXA     = 4096;
  localparam int SEEN_LIMIT   = (MAX_TAXA + 7) / 8 + 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_ITEMS = 300;

  typedef struct packed {
    status_t               status_code;
    logic [SEL_TAXA_W-1:0] sel_taxa;
  } verdict_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_SEL_PAD,
    FLAW_RET_PAD,
    FLAW_OUTSIDE,
    FLAW_EMPTY,
    FLAW_NOISE
  } flaw_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  csbc_in_if  in_bus();
  csbc_out_if out_bus();

  canonical_split_bitset_check_core #(.MAX_TAXA(MAX_TAXA)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_txn  (in_bus),
    .out_txn (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // split checker shadow state
  logic [TAXON_W-1:0]    taxa_cfg;
  logic [9:0]            seen_bytes;
  logic [SEL_TAXA_W-1:0] sel_pop;
  logic [SEL_TAXA_W-1:0] comp_pop;
  logic                  outside_hit;
  logic                  order_known;
  logic                  comp_lower;

  verdict_t    verdict_q[$];
  int          error_count;
  int unsigned pairs_accepted;
  bit          src_gaps;
  bit          sink_stalls;
  bit          hold_request;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void log_mismatch(string what, int got, int expected_val);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, expected_val);
    error_count++;
  endfunction

  function automatic void clear_query();
    seen_bytes  = '0;
    sel_pop     = '0;
    comp_pop    = '0;
    outside_hit = 1'b0;
    order_known = 1'b0;
    comp_lower  = 1'b0;
  endfunction

  function automatic void predict_pair(logic [7:0] sel, logic [7:0] ret, logic last);
    logic [7:0]  comp;
    logic [7:0]  allowed;
    int unsigned want_bytes;
    int unsigned rem;
    status_t     st;
    verdict_t    v;
    comp = sel ^ ret;
    if (seen_bytes < SEEN_LIMIT) begin
      seen_bytes++;
      sel_pop  = sel_pop + SEL_TAXA_W'($countones(sel));
      comp_pop = comp_pop + SEL_TAXA_W'($countones(comp));
    end
    if ((sel & ~ret) != 8'h00) outside_hit = 1'b1;
    if (!order_known && sel != comp) begin
      order_known = 1'b1;
      comp_lower  = comp < sel;
    end
    if (!last) return;
    want_bytes = (taxa_cfg + 7) / 8;
    rem        = taxa_cfg % 8;
    allowed    = 8'((1 << rem) - 1);
    if (taxa_cfg == 0 || taxa_cfg > MAX_TAXA || seen_bytes != want_bytes) begin
      st = STATUS_WIDTH;
    end else if (rem != 0 && (sel & ~allowed) != 8'h00) begin
      st = STATUS_SEL_PADDING;
    end else if (rem != 0 && (ret & ~allowed) != 8'h00) begin
      st = STATUS_RET_PADDING;
    end else if (outside_hit) begin
      st = STATUS_NON_RETAINED;
    end else if (sel_pop == 0 || comp_pop == 0) begin
      st = STATUS_EMPTY_SIDE;
    end else if (sel_pop > comp_pop ||
                 (sel_pop == comp_pop && order_known && comp_lower)) begin
      st = STATUS_NOT_CANONICAL;
    end else begin
      st = STATUS_OK;
    end
    v.status_code = st;
    v.sel_taxa    = sel_pop;
    verdict_q = {verdict_q, v};
    clear_query();
  endfunction

  // result sink ready: random stalls, plus one long hold on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_bus.ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_checker
    verdict_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (verdict_q.size() == 0) begin
        log_mismatch("result with no query pending, status", out_bus.status, -1);
      end else begin
        want = verdict_q.pop_front();
        if (out_bus.status !== want.status_code)
          log_mismatch("status", out_bus.status, want.status_code);
        if (out_bus.selected_taxa !== want.sel_taxa)
          log_mismatch("selected_taxa", out_bus.selected_taxa, want.sel_taxa);
      end
    end
  end

  task automatic send_pair(input logic [7:0] sel, input logic [7:0] ret, input logic last);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.selected_byte <= sel;
    in_bus.retained_byte <= ret;
    in_bus.last_byte     <= last;
    do @(posedge clk); while (!in_bus.ready);
    pairs_accepted++;
    predict_pair(sel, ret, last);
  endtask

  task automatic drain_block();
    in_bus.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_taxon_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_NUM_TAXA;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(APB_DATA_W-TAXON_W){1'b0}}, taxa_cfg})
      log_mismatch("taxa count readback", prdata, taxa_cfg);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_num_taxa(input int unsigned n);
    logic [APB_DATA_W-1:0] data;
    drain_block();
    data = $urandom;
    data[TAXON_W-1:0] = TAXON_W'(n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_NUM_TAXA;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    taxa_cfg = TAXON_W'(n);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    check_taxon_readback();
  endtask

  // up to three byte pairs, byte 0 in bits 7:0
  task automatic directed_query(input int n, input logic [23:0] sels, input logic [23:0] rets);
    int k;
    for (k = 0; k < n; k++) send_pair(sels[8*k +: 8], rets[8*k +: 8], k == n - 1);
  endtask

  task automatic random_query(input int delta, input flaw_t flaw);
    int          n;
    int unsigned rem;
    int unsigned k;
    int unsigned bad_at;
    int unsigned b;
    logic [7:0]  allowed;
    logic [7:0]  mask;
    logic [7:0]  sel;
    logic [7:0]  ret;
    rem     = taxa_cfg % 8;
    allowed = 8'((1 << rem) - 1);
    if (taxa_cfg == 0 || taxa_cfg > MAX_TAXA) n = $urandom_range(1, 4);
    else n = (taxa_cfg + 7) / 8;
    n = (n + delta < 1) ? 1 : n + delta;
    bad_at = $urandom_range(0, n - 1);
    for (k = 0; k < n; k++) begin
      mask = (k == n - 1 && rem != 0) ? allowed : 8'hFF;
      ret  = 8'($urandom_range(0, 255)) & mask;
      sel  = 8'($urandom_range(0, 255)) & ret;
      case (flaw)
        FLAW_SEL_PAD: begin
          if (k == n - 1 && rem != 0) begin
            b = $urandom_range(rem, 7);
            sel[b] = 1'b1;
          end
        end
        FLAW_RET_PAD: begin
          if (k == n - 1 && rem != 0) begin
            b = $urandom_range(rem, 7);
            ret[b] = 1'b1;
          end
        end
        FLAW_OUTSIDE: begin
          if (k == bad_at) begin
            b = $urandom_range(0, (k == n - 1 && rem != 0) ? rem - 1 : 7);
            sel[b] = 1'b1;
            ret[b] = 1'b0;
          end
        end
        FLAW_EMPTY: sel = $urandom_range(0, 1) ? 8'h00 : ret;
        FLAW_NOISE: begin
          sel = 8'($urandom_range(0, 255));
          ret = 8'($urandom_range(0, 255));
        end
        default: ;
      endcase
      send_pair(sel, ret, k == n - 1);
    end
  endtask

  task automatic random_mixed_query();
    int    r;
    int    delta;
    flaw_t flaw;
    r = $urandom_range(0, 19);
    case (r)
      12:      flaw = FLAW_SEL_PAD;
      13:      flaw = FLAW_RET_PAD;
      14:      flaw = FLAW_OUTSIDE;
      15:      flaw = FLAW_EMPTY;
      16:      flaw = FLAW_NOISE;
      default: flaw = FLAW_NONE;
    endcase
    delta = 0;
    if ($urandom_range(0, 15) == 0) delta = $urandom_range(0, 1) ? -1 : $urandom_range(1, 3);
    random_query(delta, flaw);
  endtask

  task automatic test_reset_default();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    check_taxon_readback();
    directed_query(1, 24'h00, 24'h01);
    directed_query(1, 24'h01, 24'h00);
    directed_query(1, 24'h02, 24'h02);
    directed_query(1, 24'hFF, 24'hFF);
  endtask

  task automatic test_directed_checks();
    set_num_taxa(10);
    directed_query(2, 24'h0001, 24'h0003);
    directed_query(2, 24'h0002, 24'h0003);
    directed_query(2, 24'h01FF, 24'h03FF);
    directed_query(2, 24'h0000, 24'h03FF);
    directed_query(2, 24'h0001, 24'h0000);
    directed_query(2, 24'h0400, 24'h0400);
    directed_query(2, 24'h0000, 24'h8000);
    directed_query(1, 24'h0F, 24'hFF);
    directed_query(3, 24'hFF0000, 24'hFFFFFF);
    directed_query(2, 24'h0055, 24'h00FF);
    set_num_taxa(8);
    directed_query(1, 24'h80, 24'hFF);
    set_num_taxa(0);
    directed_query(1, 24'hFF, 24'hFF);
    set_num_taxa(13'h1FFF);
    directed_query(1, 24'h00, 24'h00);
    set_num_taxa(MAX_TAXA + 1);
    directed_query(1, 24'h01, 24'h03);
  endtask

  task automatic test_backpressure();
    set_num_taxa(8);
    src_gaps     = 1'b0;
    hold_request = 1'b1;
    repeat (16) random_query(0, FLAW_NONE);
    src_gaps = 1'b1;
    drain_block();
  endtask

  task automatic test_long_streams();
    // widest query, two bytes past its width: the byte count stops at its cap
    set_num_taxa(MAX_TAXA);
    random_query(2, FLAW_NONE);
  endtask

  task automatic test_random_phases();
    int unsigned stop_at;
    stop_at = pairs_accepted + RANDOM_ITEMS;
    while (pairs_accepted < stop_at) begin
      src_gaps    = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 7))
        0:       set_num_taxa(1);
        1:       set_num_taxa(8);
        2:       set_num_taxa(0);
        3:       set_num_taxa($urandom_range(MAX_TAXA + 1, 8191));
        4:       set_num_taxa($urandom_range(65, 300));
        default: set_num_taxa($urandom_range(2, 64));
      endcase
      repeat ($urandom_range(4, 12)) random_mixed_query();
    end
  endtask

  task automatic test_quiet_tail();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    set_num_taxa($urandom_range(2, 64));
    repeat (30) random_mixed_query();
  endtask

  initial begin
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_bus.valid         = 1'b0;
    in_bus.selected_byte = '0;
    in_bus.retained_byte = '0;
    in_bus.last_byte     = 1'b0;
    error_count          = 0;
    pairs_accepted       = 0;
    src_gaps             = 1'b0;
    sink_stalls          = 1'b0;
    hold_request         = 1'b0;
    taxa_cfg             = NUM_TAXA_RST;
    clear_query();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_default();
    test_directed_checks();
    test_backpressure();
    test_long_streams();
    test_random_phases();
    test_quiet_tail();
    drain_block();
    if (error_count == 0) begin
      $display("canonical_split_bitset_check_core_tb: clean");
    end else begin
      $display("canonical_split_bitset_check_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #1200000;
    $display("canonical_split_bitset_check_core_tb: errors");
    $finish;
  end

endmodule
